// ===== sv/iir_direct_form_one_filter_assert.svh =====
// Assertion helpers; clocked on clk_i, disabled while rst_ni is low.
`ifndef IIR_DIRECT_FORM_ONE_FILTER_ASSERT_SVH
`define IIR_DIRECT_FORM_ONE_FILTER_ASSERT_SVH

`ifndef SYNTH
`define IIRDF1_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define IIRDF1_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IIRDF1_ASSERT_SAME(lbl, ante, cons, msg)
`define IIRDF1_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/iirdf1_pkg.sv =====
package iirdf1_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 24;
  localparam int SCALE_W   = 16;
  localparam int SUM_W     = 24;
  localparam int PROD_W    = 2 * COEF_W;
  localparam int ACC_W     = 52;
  localparam int STEP_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_W    = 20;
  localparam int SCALE_FRAC_W = 8;

  // taps that carry a programmable weight; further taps weigh zero
  localparam int COEF_TAPS = 3;

  localparam int FF_TAPS_DEF = 3;
  localparam int FB_TAPS_DEF = 3;

  localparam logic signed [COEF_W-1:0]  B0_RESET    = 24'sd1048576;
  localparam logic signed [SCALE_W-1:0] SCALE_RESET = 16'sd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0    = 3'd0,
    REG_B1    = 3'd1,
    REG_B2    = 3'd2,
    REG_A1    = 3'd3,
    REG_A2    = 3'd4,
    REG_SCALE = 3'd5
  } reg_idx_e;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    coef_t                     b0;
    coef_t                     b1;
    coef_t                     b2;
    coef_t                     a1;
    coef_t                     a2;
    logic signed [SCALE_W-1:0] scale;
  } coefs_t;

  typedef struct packed {
    logic              mul_en;
    logic              mul_scale;
    logic [STEP_W-1:0] step;
    logic              acc_clr;
    logic              acc_en;
    logic              acc_sub;
    logic              push;
    logic              out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

  // round half up at bit FRAC_W, saturate to SUM_W bits
  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0]        t;
    logic signed [ACC_W-FRAC_W-1:0] s;
    logic signed [ACC_W-FRAC_W-1:0] hi;
    logic signed [ACC_W-FRAC_W-1:0] lo;
    t  = acc + (ACC_W'(1) <<< (FRAC_W - 1));
    s  = t[ACC_W-1:FRAC_W];
    hi = (ACC_W-FRAC_W)'({1'b0, {(SUM_W-1){1'b1}}});
    lo = -hi - (ACC_W-FRAC_W)'(1);
    if (s > hi) begin
      sat_sum = {1'b0, {(SUM_W-1){1'b1}}};
    end else if (s < lo) begin
      sat_sum = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      sat_sum = s[SUM_W-1:0];
    end
  endfunction

  // round half up at bit SCALE_FRAC_W, saturate to SAMPLE_W bits
  function automatic logic signed [SAMPLE_W-1:0] sat_out(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0]              t;
    logic signed [PROD_W-SCALE_FRAC_W-1:0] s;
    logic signed [PROD_W-SCALE_FRAC_W-1:0] hi;
    logic signed [PROD_W-SCALE_FRAC_W-1:0] lo;
    t  = p + (PROD_W'(1) <<< (SCALE_FRAC_W - 1));
    s  = t[PROD_W-1:SCALE_FRAC_W];
    hi = (PROD_W-SCALE_FRAC_W)'({1'b0, {(SAMPLE_W-1){1'b1}}});
    lo = -hi - (PROD_W-SCALE_FRAC_W)'(1);
    if (s > hi) begin
      sat_out = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (s < lo) begin
      sat_out = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sat_out = s[SAMPLE_W-1:0];
    end
  endfunction

endpackage

// ===== sv/iirdf1_cfg.sv =====
module iirdf1_cfg import iirdf1_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [COEF_W-1:0]    cfg_wdata_i,
  output coefs_t               coefs_o
);

  coefs_t coefs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coefs_q.b0    <= B0_RESET;
      coefs_q.b1    <= '0;
      coefs_q.b2    <= '0;
      coefs_q.a1    <= '0;
      coefs_q.a2    <= '0;
      coefs_q.scale <= SCALE_RESET;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_B0:    coefs_q.b0    <= cfg_wdata_i;
        REG_B1:    coefs_q.b1    <= cfg_wdata_i;
        REG_B2:    coefs_q.b2    <= cfg_wdata_i;
        REG_A1:    coefs_q.a1    <= cfg_wdata_i;
        REG_A2:    coefs_q.a2    <= cfg_wdata_i;
        REG_SCALE: coefs_q.scale <= cfg_wdata_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign coefs_o = coefs_q;

endmodule

// ===== sv/iirdf1_ctrl.sv =====
`include "iir_direct_form_one_filter_assert.svh"

module iirdf1_ctrl import iirdf1_pkg::*; #(
  parameter int FF_TAPS = FF_TAPS_DEF,
  parameter int FB_TAPS = FB_TAPS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam int NFF   = (FF_TAPS < COEF_TAPS) ? FF_TAPS : COEF_TAPS;
  localparam int NFB   = ((FB_TAPS < COEF_TAPS) ? FB_TAPS : COEF_TAPS) - 1;
  localparam int NSTEP = NFF + NFB;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_ROUND,
    S_SCALE,
    S_OUT
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [STEP_W-1:0] prev_step;

  assign prev_step = step_q - STEP_W'(1);

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          // first product (b0 times the new sample) issues on the accept beat
          cmd_o.mul_en  = 1'b1;
          cmd_o.step    = '0;
          cmd_o.acc_clr = 1'b1;
          step_d        = STEP_W'(1);
          state_d       = (NSTEP > 1) ? S_MAC : S_DRAIN;
        end
      end
      S_MAC: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.step    = step_q;
        cmd_o.acc_en  = 1'b1;
        cmd_o.acc_sub = (prev_step >= STEP_W'(NFF));
        if (step_q == STEP_W'(NSTEP - 1)) begin
          state_d = S_DRAIN;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      S_DRAIN: begin
        cmd_o.acc_en  = 1'b1;
        cmd_o.acc_sub = (NFB > 0);
        state_d       = S_ROUND;
      end
      S_ROUND: begin
        cmd_o.push = 1'b1;
        state_d    = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_scale = 1'b1;
        state_d         = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  `IIRDF1_ASSERT_SAME(a_load_free, cmd_o.out_load, sts_i.out_free, "output register overwritten")
  `IIRDF1_ASSERT_NEXT(a_accept_starts, in_valid_i && in_ready_o,
                      state_q == S_MAC || state_q == S_DRAIN, "accept did not start MAC")
  `IIRDF1_ASSERT_NEXT(a_push_then_scale, cmd_o.push, cmd_o.mul_scale,
                      "scale product not issued after history push")
  `IIRDF1_ASSERT_SAME(a_mul_excl, cmd_o.mul_en, !cmd_o.push && !cmd_o.out_load,
                      "multiplier issued during round or output")

endmodule

// ===== sv/iirdf1_dp.sv =====
module iirdf1_dp import iirdf1_pkg::*; #(
  parameter int FF_TAPS = FF_TAPS_DEF,
  parameter int FB_TAPS = FB_TAPS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  coefs_t                     coefs_i,
  input  dp_cmd_t                    cmd_i,
  output dp_sts_t                    sts_o,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o
);

  localparam int NFF  = (FF_TAPS < COEF_TAPS) ? FF_TAPS : COEF_TAPS;
  localparam int IH_D = (FF_TAPS > 1) ? FF_TAPS - 1 : 1;
  localparam int OH_D = (FB_TAPS > 1) ? FB_TAPS - 1 : 1;

  logic signed [SAMPLE_W-1:0] ih_q [IH_D];
  logic signed [SUM_W-1:0]    oh_q [OH_D];
  logic signed [SAMPLE_W-1:0] ih_tap [COEF_TAPS-1];
  logic signed [SUM_W-1:0]    oh_tap [COEF_TAPS-1];

  logic signed [SAMPLE_W-1:0] x_q;
  logic signed [SUM_W-1:0]    sum_q;
  logic signed [SUM_W-1:0]    sum_new;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [ACC_W-1:0]    prod_ext;
  logic signed [COEF_W-1:0]   op_coef;
  logic signed [COEF_W-1:0]   op_data;
  logic [STEP_W-1:0]          ih_sel;
  logic [STEP_W-1:0]          fb_sel;
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_data_q;

  // only the first taps carry a weight; missing history reads as zero
  for (genvar k = 0; k < COEF_TAPS - 1; k++) begin : g_tap
    if (k < FF_TAPS - 1) begin : g_ih
      assign ih_tap[k] = ih_q[k];
    end else begin : g_ih0
      assign ih_tap[k] = '0;
    end
    if (k < FB_TAPS - 1) begin : g_oh
      assign oh_tap[k] = oh_q[k];
    end else begin : g_oh0
      assign oh_tap[k] = '0;
    end
  end

  assign ih_sel = cmd_i.step - STEP_W'(1);
  assign fb_sel = cmd_i.step - STEP_W'(NFF);

  always_comb begin
    if (cmd_i.mul_scale) begin
      op_coef = COEF_W'(coefs_i.scale);
      op_data = sum_q;
    end else if (cmd_i.step < STEP_W'(NFF)) begin
      case (cmd_i.step[1:0])
        2'd0:    op_coef = coefs_i.b0;
        2'd1:    op_coef = coefs_i.b1;
        default: op_coef = coefs_i.b2;
      endcase
      if (cmd_i.step == '0) begin
        op_data = COEF_W'(sample_in_i);
      end else begin
        op_data = COEF_W'(ih_tap[ih_sel[0]]);
      end
    end else begin
      op_coef = fb_sel[0] ? coefs_i.a2 : coefs_i.a1;
      op_data = oh_tap[fb_sel[0]];
    end
  end

  assign prod_ext = ACC_W'(prod_q);
  assign sum_new  = sat_sum(acc_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= op_coef * op_data;
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
      x_q   <= sample_in_i;
    end else if (cmd_i.acc_en) begin
      acc_q <= cmd_i.acc_sub ? acc_q - prod_ext : acc_q + prod_ext;
    end
    if (cmd_i.push) begin
      sum_q <= sum_new;
    end
    if (cmd_i.out_load) begin
      out_data_q <= sat_out(prod_q);
    end
  end

  if (FF_TAPS > 1) begin : g_ih_shift
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        for (int i = 0; i < IH_D; i++) ih_q[i] <= '0;
      end else if (cmd_i.push) begin
        for (int i = IH_D - 1; i > 0; i--) ih_q[i] <= ih_q[i-1];
        ih_q[0] <= x_q;
      end
    end
  end else begin : g_ih_none
    assign ih_q[0] = '0;
  end

  if (FB_TAPS > 1) begin : g_oh_shift
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        for (int i = 0; i < OH_D; i++) oh_q[i] <= '0;
      end else if (cmd_i.push) begin
        for (int i = OH_D - 1; i > 0; i--) oh_q[i] <= oh_q[i-1];
        oh_q[0] <= sum_new;
      end
    end
  end else begin : g_oh_none
    assign oh_q[0] = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign sample_out_o   = out_data_q;

endmodule

// ===== sv/iir_direct_form_one_filter.sv =====
// Per input beat: b0 product on accept, MAC over the other weighted taps, drain,
//   round and push, level scale, output load once the output register is free.
//   NSTEP = min(FF_TAPS,3) + min(FB_TAPS,3) - 1 weighted taps. No new sample is taken
//   until output load; one shared 24x24 multiplier computes all tap and scale products.
// Reset (rst_ni low, async): histories clear, b0 = 1.0, level scale = 1.0, others 0.
module iir_direct_form_one_filter import iirdf1_pkg::*; #(
  parameter int FF_TAPS = FF_TAPS_DEF,
  parameter int FB_TAPS = FB_TAPS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [SAMPLE_W-1:0]  s_axis_tdata,   // [15:0] sample_in
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [SAMPLE_W-1:0]  m_axis_tdata,   // [15:0] sample_out
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [COEF_W-1:0]    cfg_wdata_i
);

  coefs_t  coefs;
  dp_cmd_t cmd;
  dp_sts_t sts;

  iirdf1_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coefs_o     (coefs)
  );

  iirdf1_ctrl #(
    .FF_TAPS (FF_TAPS),
    .FB_TAPS (FB_TAPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  iirdf1_dp #(
    .FF_TAPS (FF_TAPS),
    .FB_TAPS (FB_TAPS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .coefs_i      (coefs),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .sample_in_i  (s_axis_tdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .sample_out_o (m_axis_tdata)
  );

endmodule
